// File: src/hyperbolic_cordic_cosh_sinh_assert.svh
// assertion macros for the hyperbolic cordic block
// no dependencies; SYNTHESIS selects empty bodies
`ifndef HYPERBOLIC_CORDIC_COSH_SINH_ASSERT_SVH
`define HYPERBOLIC_CORDIC_COSH_SINH_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define HCC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HCC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define HCC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define HCC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: src/hcc_pkg.sv
// shared types, constants, micro-program and angle table for the cordic block
// no dependencies
`timescale 1ns / 1ps

package hcc_pkg;

  localparam int unsigned MAX_ITERATIONS = 40;
  localparam int unsigned FRACTION_BITS  = 24;
  localparam int unsigned WORD_W         = 32;
  localparam int unsigned DATA_W         = 36;
  localparam int unsigned ATANH_W        = 24;
  localparam int unsigned CNT_W          = 6;
  localparam int unsigned PC_W           = 6;
  localparam int unsigned PADDR_W        = 3;
  localparam int unsigned PDATA_W        = 32;

  localparam logic [CNT_W-1:0] ITER_RESET = CNT_W'(20);
  localparam logic [CNT_W-1:0] ITER_MAX   = CNT_W'(MAX_ITERATIONS);

  // register indexes
  localparam logic [0:0] REG_ITERATION_COUNT = 1'b0;

  // fixed-point constants
  localparam logic signed [DATA_W-1:0] ONE_Q  = DATA_W'(64'sd1 <<< FRACTION_BITS);
  localparam logic signed [WORD_W-1:0] PI_Q   = 32'sd52707179;
  localparam logic signed [WORD_W-1:0] ONE_W  = 32'sh0100_0000;
  localparam logic signed [WORD_W-1:0] MONE_W = -32'sh0100_0000;

  // micro-program addresses
  localparam logic [PC_W-1:0] PC_INIT   = PC_W'(0);
  localparam logic [PC_W-1:0] PC_FINISH = PC_W'(44);

  typedef enum logic [1:0] {
    OP_INIT,
    OP_ROT,
    OP_DONE
  } uop_e;

  typedef struct packed {
    uop_e             op;
    logic [CNT_W-1:0] shift;
    logic             chk;
  } uword_t;

  typedef struct packed {
    logic             load;
    logic             rotate;
    logic             finish;
    logic [CNT_W-1:0] shift;
  } ctrl_t;

  typedef struct packed {
    logic oor;
  } stat_t;

  typedef struct packed {
    logic [WORD_W-1:0] cosh;
    logic [WORD_W-1:0] sinh;
    logic              oor;
  } res_t;

  // control store: init, 43 rotations (shifts 4, 13, 40 twice), finish
  function automatic uword_t urom(input logic [PC_W-1:0] addr);
    uword_t w;
    unique case (addr)
      6'd0:    w = '{OP_INIT, 6'd0, 1'b0};
      6'd1:    w = '{OP_ROT, 6'd1, 1'b1};
      6'd2:    w = '{OP_ROT, 6'd2, 1'b1};
      6'd3:    w = '{OP_ROT, 6'd3, 1'b1};
      6'd4:    w = '{OP_ROT, 6'd4, 1'b0};
      6'd5:    w = '{OP_ROT, 6'd4, 1'b1};
      6'd6:    w = '{OP_ROT, 6'd5, 1'b1};
      6'd7:    w = '{OP_ROT, 6'd6, 1'b1};
      6'd8:    w = '{OP_ROT, 6'd7, 1'b1};
      6'd9:    w = '{OP_ROT, 6'd8, 1'b1};
      6'd10:   w = '{OP_ROT, 6'd9, 1'b1};
      6'd11:   w = '{OP_ROT, 6'd10, 1'b1};
      6'd12:   w = '{OP_ROT, 6'd11, 1'b1};
      6'd13:   w = '{OP_ROT, 6'd12, 1'b1};
      6'd14:   w = '{OP_ROT, 6'd13, 1'b0};
      6'd15:   w = '{OP_ROT, 6'd13, 1'b1};
      6'd16:   w = '{OP_ROT, 6'd14, 1'b1};
      6'd17:   w = '{OP_ROT, 6'd15, 1'b1};
      6'd18:   w = '{OP_ROT, 6'd16, 1'b1};
      6'd19:   w = '{OP_ROT, 6'd17, 1'b1};
      6'd20:   w = '{OP_ROT, 6'd18, 1'b1};
      6'd21:   w = '{OP_ROT, 6'd19, 1'b1};
      6'd22:   w = '{OP_ROT, 6'd20, 1'b1};
      6'd23:   w = '{OP_ROT, 6'd21, 1'b1};
      6'd24:   w = '{OP_ROT, 6'd22, 1'b1};
      6'd25:   w = '{OP_ROT, 6'd23, 1'b1};
      6'd26:   w = '{OP_ROT, 6'd24, 1'b1};
      6'd27:   w = '{OP_ROT, 6'd25, 1'b1};
      6'd28:   w = '{OP_ROT, 6'd26, 1'b1};
      6'd29:   w = '{OP_ROT, 6'd27, 1'b1};
      6'd30:   w = '{OP_ROT, 6'd28, 1'b1};
      6'd31:   w = '{OP_ROT, 6'd29, 1'b1};
      6'd32:   w = '{OP_ROT, 6'd30, 1'b1};
      6'd33:   w = '{OP_ROT, 6'd31, 1'b1};
      6'd34:   w = '{OP_ROT, 6'd32, 1'b1};
      6'd35:   w = '{OP_ROT, 6'd33, 1'b1};
      6'd36:   w = '{OP_ROT, 6'd34, 1'b1};
      6'd37:   w = '{OP_ROT, 6'd35, 1'b1};
      6'd38:   w = '{OP_ROT, 6'd36, 1'b1};
      6'd39:   w = '{OP_ROT, 6'd37, 1'b1};
      6'd40:   w = '{OP_ROT, 6'd38, 1'b1};
      6'd41:   w = '{OP_ROT, 6'd39, 1'b1};
      6'd42:   w = '{OP_ROT, 6'd40, 1'b0};
      6'd43:   w = '{OP_ROT, 6'd40, 1'b1};
      default: w = '{OP_DONE, 6'd0, 1'b0};
    endcase
    return w;
  endfunction

  // atanh(2^-k) in q.24, rounded to nearest
  function automatic logic [ATANH_W-1:0] atanh_tab(input logic [CNT_W-1:0] k);
    logic [ATANH_W-1:0] a;
    unique case (k)
      6'd1:    a = 24'd9215828;
      6'd2:    a = 24'd4285116;
      6'd3:    a = 24'd2108178;
      6'd4:    a = 24'd1049945;
      6'd5:    a = 24'd524459;
      6'd6:    a = 24'd262165;
      6'd7:    a = 24'd131075;
      6'd8:    a = 24'd65536;
      6'd9:    a = 24'd32768;
      6'd10:   a = 24'd16384;
      6'd11:   a = 24'd8192;
      6'd12:   a = 24'd4096;
      6'd13:   a = 24'd2048;
      6'd14:   a = 24'd1024;
      6'd15:   a = 24'd512;
      6'd16:   a = 24'd256;
      6'd17:   a = 24'd128;
      6'd18:   a = 24'd64;
      6'd19:   a = 24'd32;
      6'd20:   a = 24'd16;
      6'd21:   a = 24'd8;
      6'd22:   a = 24'd4;
      6'd23:   a = 24'd2;
      6'd24:   a = 24'd1;
      6'd25:   a = 24'd1;
      default: a = 24'd0;
    endcase
    return a;
  endfunction

endpackage

// File: src/hyperbolic_cordic_cosh_sinh.sv
// Unscaled hyperbolic cordic cosh/sinh, microcoded, one angle at a time.
// Per angle: a load on accept, an init step, one shift-add rotation per cycle
// up to the clamped count (shifts 4, 13, 40 twice), and a done step that waits
// for a free output register; out of range or zero iterations skip rotations.
// No new angle is taken until the done step ends. Async reset clears the sequencer,
// output valid and sets iteration_count to 20; no memory to clear.
`timescale 1ns / 1ps
`include "hyperbolic_cordic_cosh_sinh_assert.svh"

module hyperbolic_cordic_cosh_sinh import hcc_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [PADDR_W-1:0]       paddr,
  input  logic [PDATA_W-1:0]       pwdata,
  output logic [PDATA_W-1:0]       prdata,
  output logic                     pready,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [WORD_W-1:0] angle_in_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [WORD_W-1:0] cosh_out_o,
  output logic signed [WORD_W-1:0] sinh_out_o,
  output logic                     out_of_range_o
);

  logic [CNT_W-1:0] iter;
  logic             busy;
  logic             out_free;
  ctrl_t            ctrl;
  stat_t            stat;
  res_t             res;

  logic             out_valid_q, out_valid_d;
  res_t             out_q;

  hcc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .iter_o  (iter)
  );

  hcc_useq u_useq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_valid_i),
    .out_free_i (out_free),
    .iter_i     (iter),
    .stat_i     (stat),
    .busy_o     (busy),
    .ctrl_o     (ctrl)
  );

  hcc_datapath u_dp (
    .clk_i   (clk_i),
    .angle_i (angle_in_i),
    .ctrl_i  (ctrl),
    .stat_o  (stat),
    .res_o   (res)
  );

  assign in_ready_o = ~busy;
  assign out_free   = ~out_valid_q | out_ready_i;

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl.finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.finish) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign cosh_out_o     = out_q.cosh;
  assign sinh_out_o     = out_q.sinh;
  assign out_of_range_o = out_q.oor;

  // checks
  `HCC_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o, "not busy after accept")
  `HCC_ASSERT_NOW(a_finish_slot_free, clk_i, rst_ni, ctrl.finish, !out_valid_o || out_ready_i, "result overwritten")
  `HCC_ASSERT_NOW(a_rotate_only_busy, clk_i, rst_ni, ctrl.rotate, !in_ready_o, "rotation while idle")
  `HCC_ASSERT_NOW(a_oor_cosh_one, clk_i, rst_ni, out_valid_o && out_of_range_o, cosh_out_o == ONE_W, "bad out-of-range cosh")

endmodule

// File: src/hcc_cfg.sv
// apb-style configuration register: iteration count
// depends on hcc_pkg
`timescale 1ns / 1ps

module hcc_cfg import hcc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output logic [CNT_W-1:0]   iter_o
);

  logic [CNT_W-1:0] iter_q, iter_d;
  logic             wr_en;
  logic             hit;

  assign pready = 1'b1;
  assign hit    = (paddr[PADDR_W-1] == REG_ITERATION_COUNT);
  assign wr_en  = psel & penable & pwrite & hit;

  // register write
  always_comb begin
    iter_d = iter_q;
    if (wr_en) begin
      iter_d = pwdata[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iter_q <= ITER_RESET;
    end else begin
      iter_q <= iter_d;
    end
  end

  // read back
  assign prdata = hit ? {{(PDATA_W-CNT_W){1'b0}}, iter_q} : '0;
  assign iter_o = iter_q;

endmodule

// File: src/hcc_useq.sv
// micro-sequencer: step counter, control store and conditional jumps
// depends on hcc_pkg
`timescale 1ns / 1ps

module hcc_useq import hcc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             out_free_i,
  input  logic [CNT_W-1:0] iter_i,
  input  stat_t            stat_i,
  output logic             busy_o,
  output ctrl_t            ctrl_o
);

  logic            busy_q, busy_d;
  logic [PC_W-1:0] pc_q, pc_d;
  uword_t          uw;
  logic [CNT_W-1:0] n_sat;

  // clamp the programmed count
  assign n_sat = (iter_i > ITER_MAX) ? ITER_MAX : iter_i;
  assign uw    = urom(pc_q);

  // step and jump logic
  always_comb begin
    busy_d        = busy_q;
    pc_d          = pc_q;
    ctrl_o.load   = 1'b0;
    ctrl_o.rotate = 1'b0;
    ctrl_o.finish = 1'b0;
    ctrl_o.shift  = uw.shift;
    if (!busy_q) begin
      if (start_i) begin
        busy_d      = 1'b1;
        pc_d        = PC_INIT;
        ctrl_o.load = 1'b1;
      end
    end else begin
      unique case (uw.op)
        OP_INIT: begin
          if (stat_i.oor || (n_sat == '0)) begin
            pc_d = PC_FINISH;
          end else begin
            pc_d = pc_q + PC_W'(1);
          end
        end
        OP_ROT: begin
          ctrl_o.rotate = 1'b1;
          if (uw.chk && (uw.shift == n_sat)) begin
            pc_d = PC_FINISH;
          end else begin
            pc_d = pc_q + PC_W'(1);
          end
        end
        OP_DONE: begin
          if (out_free_i) begin
            ctrl_o.finish = 1'b1;
            busy_d        = 1'b0;
          end
        end
        default: begin
          busy_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pc_q   <= PC_INIT;
    end else begin
      busy_q <= busy_d;
      pc_q   <= pc_d;
    end
  end

  assign busy_o = busy_q;

endmodule

// File: src/hcc_datapath.sv
// shift-add datapath: x, y, z registers, angle table, range check, sign fix
// depends on hcc_pkg
`timescale 1ns / 1ps

module hcc_datapath import hcc_pkg::*; (
  input  logic                     clk_i,
  input  logic signed [WORD_W-1:0] angle_i,
  input  ctrl_t                    ctrl_i,
  output stat_t                    stat_o,
  output res_t                     res_o
);

  logic signed [DATA_W-1:0] x_q, x_d, y_q, y_d, z_q, z_d;
  logic                     neg_q, neg_d, oor_q, oor_d;
  logic signed [DATA_W-1:0] dx, dy, a;
  logic signed [DATA_W-1:0] x_fix, y_fix;

  // one rotation step
  assign dx = y_q >>> ctrl_i.shift;
  assign dy = x_q >>> ctrl_i.shift;
  assign a  = $signed({{(DATA_W-ATANH_W){1'b0}}, atanh_tab(ctrl_i.shift)});

  always_comb begin
    x_d   = x_q;
    y_d   = y_q;
    z_d   = z_q;
    neg_d = neg_q;
    oor_d = oor_q;
    if (ctrl_i.load) begin
      x_d   = ONE_Q;
      y_d   = '0;
      z_d   = DATA_W'(angle_i);
      neg_d = angle_i[WORD_W-1];
      oor_d = (angle_i < -PI_Q) || (angle_i > PI_Q);
    end else if (ctrl_i.rotate) begin
      if (z_q[DATA_W-1]) begin
        x_d = x_q - dx;
        y_d = y_q - dy;
        z_d = z_q + a;
      end else begin
        x_d = x_q + dx;
        y_d = y_q + dy;
        z_d = z_q - a;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    z_q   <= z_d;
    neg_q <= neg_d;
    oor_q <= oor_d;
  end

  // negate for a negative angle, fixed values out of range
  assign x_fix = neg_q ? -x_q : x_q;
  assign y_fix = neg_q ? -y_q : y_q;

  always_comb begin
    if (oor_q) begin
      res_o.cosh = ONE_W;
      res_o.sinh = neg_q ? MONE_W : ONE_W;
    end else begin
      res_o.cosh = x_fix[WORD_W-1:0];
      res_o.sinh = y_fix[WORD_W-1:0];
    end
    res_o.oor = oor_q;
  end

  assign stat_o.oor = oor_q;

endmodule

// File: verif/testbench.sv
// testbench for hyperbolic_cordic_cosh_sinh: directed and random angles checked
// against a shift-add cordic predictor; depends on hcc_pkg and the block rtl
`timescale 1ns / 1ps

module testbench;
  import hcc_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int unsigned DRAIN_CYCLES = 60;
  localparam int unsigned RAND_PHASES  = 10;
  localparam int unsigned PHASE_WORDS  = 45;
  localparam int unsigned REG_SPARE    = 1;  // index with no register behind it
  localparam longint PI_FIX = longint'((64'h3243_F6A8_885A_308D + (64'd1 << 35)) >> 36);
  localparam logic [WORD_W-1:0] PI_W      = WORD_W'(PI_FIX);
  localparam logic [WORD_W-1:0] ONE_FIX   = 32'h0100_0000;
  localparam logic [WORD_W-1:0] M_ONE_FIX = 32'hFF00_0000;

  // one directed probe: iteration setting, angle, optional hand-typed result
  typedef struct packed {
    logic [CNT_W-1:0]  iters;
    logic [WORD_W-1:0] angle;
    logic              typed;
    logic [WORD_W-1:0] cosh;
    logic [WORD_W-1:0] sinh;
    logic              oor;
  } probe_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [PDATA_W-1:0]  pwdata = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [WORD_W-1:0]   angle_in_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [WORD_W-1:0]   cosh_out_o;
  logic [WORD_W-1:0]   sinh_out_o;
  logic                out_of_range_o;

  res_t              cosh_sinh_q[$];
  longint            atanh_fix[1:MAX_ITERATIONS];
  logic [CNT_W-1:0]  iter_setting = ITER_RESET;
  int unsigned       mismatch_count = 0;
  int unsigned       cycle_count = 0;
  probe_t            probes[$];

  hyperbolic_cordic_cosh_sinh DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .angle_in_i     (angle_in_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .cosh_out_o     (cosh_out_o),
    .sinh_out_o     (sinh_out_o),
    .out_of_range_o (out_of_range_o)
  );

  always #2 clk_i = ~clk_i;

  // cosh/sinh of one angle at a given iteration setting
  function automatic res_t predict_cosh_sinh(input logic [WORD_W-1:0] ang,
                                             input logic [CNT_W-1:0] iters);
    res_t        r;
    longint      x;
    longint      y;
    longint      z;
    longint      dx;
    longint      dy;
    int unsigned n;
    int unsigned j;
    int unsigned passes;
    bit          neg;
    z = longint'(signed'(ang));
    neg = z < 0;
    if (z < -PI_FIX || z > PI_FIX) begin
      r.cosh = ONE_FIX;
      r.sinh = neg ? M_ONE_FIX : ONE_FIX;
      r.oor = 1'b1;
      return r;
    end
    n = (iters > MAX_ITERATIONS) ? MAX_ITERATIONS : iters;
    x = longint'(1) << FRACTION_BITS;
    y = 0;
    for (j = 1; j <= n; j++) begin
      // shifts 4, 13 and 40 are taken twice
      passes = (j == 4 || j == 13 || j == 40) ? 2 : 1;
      repeat (passes) begin
        dx = y >>> j;
        dy = x >>> j;
        if (z < 0) begin
          x = x - dx;
          y = y - dy;
          z = z + atanh_fix[j];
        end else begin
          x = x + dx;
          y = y + dy;
          z = z - atanh_fix[j];
        end
      end
    end
    if (neg) begin
      x = -x;
      y = -y;
    end
    r.cosh = x[WORD_W-1:0];
    r.sinh = y[WORD_W-1:0];
    r.oor = 1'b0;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                 input logic [WORD_W-1:0] want);
    $display("[%0d] mismatch %s: got %h want %h", cycle_count, what, got, want);
    mismatch_count++;
  endtask

  // apb transfer: setup then access, pready is always high
  task automatic apb_access(input bit wr, input int unsigned index,
                            input logic [PDATA_W-1:0] data, output logic [PDATA_W-1:0] rd);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= PADDR_W'(4 * index);
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    rd = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // drain the block, then write the iteration count and read it back
  task automatic set_iterations(input logic [CNT_W-1:0] iters, input bit dirty_upper);
    logic [PDATA_W-1:0] data;
    logic [PDATA_W-1:0] rd;
    in_valid_i <= 1'b0;
    while (cosh_sinh_q.size() != 0) @(posedge clk_i);
    data = dirty_upper ? ({$urandom()} & ~PDATA_W'(6'h3F)) : '0;
    data[CNT_W-1:0] = iters;
    apb_access(1'b1, REG_ITERATION_COUNT, data, rd);
    iter_setting = iters;
    apb_access(1'b0, REG_ITERATION_COUNT, '0, rd);
    if (rd !== PDATA_W'(iter_setting)) report_mismatch("iteration_count readback", rd,
                                                        PDATA_W'(iter_setting));
  endtask

  // hold one angle word until accepted, then queue its result
  task automatic send_angle(input logic [WORD_W-1:0] ang, input res_t want);
    in_valid_i <= 1'b1;
    angle_in_i <= ang;
    do @(posedge clk_i); while (!in_ready_o);
    cosh_sinh_q.push_back(want);
  endtask

  // receiver stall pattern and run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    case (cycle_count[10:9])
      2'd0:    out_ready_i <= 1'b1;
      2'd1:    out_ready_i <= ($urandom_range(0, 3) != 0);
      2'd2:    out_ready_i <= ((cycle_count % 7) < 3);
      default: out_ready_i <= $urandom_range(0, 1);
    endcase
    if (cycle_count > LIMIT_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result checking against the oldest expectation
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (cosh_sinh_q.size() == 0) begin
        report_mismatch("word with no angle pending", cosh_out_o, '0);
      end else begin
        want = cosh_sinh_q.pop_front();
        if (cosh_out_o !== want.cosh) report_mismatch("cosh_out", cosh_out_o, want.cosh);
        if (sinh_out_o !== want.sinh) report_mismatch("sinh_out", sinh_out_o, want.sinh);
        if (out_of_range_o !== want.oor)
          report_mismatch("out_of_range", WORD_W'(out_of_range_o), WORD_W'(want.oor));
      end
    end
  end

  initial begin
    longint unsigned    acc;
    longint unsigned    k;
    longint unsigned    m;
    logic [PDATA_W-1:0] rd;
    logic [WORD_W-1:0]  ang;
    res_t               want;
    int unsigned        burst_left;
    int unsigned        gap;
    int unsigned        phase;
    int unsigned        sel;
    int unsigned        i;
    logic [CNT_W-1:0]   phase_iters[RAND_PHASES];

    // atanh(2^-k) by its odd power series, rounded to the fraction width
    for (k = 1; k <= MAX_ITERATIONS; k++) begin
      acc = 0;
      for (m = 1; k * m <= 62; m += 2) acc += ((64'd1 << 62) >> (k * m)) / m;
      atanh_fix[k] = longint'((acc + (64'd1 << (61 - FRACTION_BITS))) >> (62 - FRACTION_BITS));
    end

    // directed probes: range edges, exact pi, zero and saturated iteration counts
    probes.push_back('{6'd20, 32'h7FFF_FFFF, 1'b1, ONE_FIX, ONE_FIX, 1'b1});
    probes.push_back('{6'd20, 32'h8000_0000, 1'b1, ONE_FIX, M_ONE_FIX, 1'b1});
    probes.push_back('{6'd20, PI_W + 1, 1'b1, ONE_FIX, ONE_FIX, 1'b1});
    probes.push_back('{6'd20, -PI_W - 1, 1'b1, ONE_FIX, M_ONE_FIX, 1'b1});
    probes.push_back('{6'd20, PI_W, 1'b0, 32'h0, 32'h0, 1'b0});
    probes.push_back('{6'd20, -PI_W, 1'b0, 32'h0, 32'h0, 1'b0});
    probes.push_back('{6'd20, 32'h0000_0000, 1'b0, 32'h0, 32'h0, 1'b0});
    probes.push_back('{6'd20, 32'h0000_0001, 1'b0, 32'h0, 32'h0, 1'b0});
    probes.push_back('{6'd20, 32'hFFFF_FFFF, 1'b0, 32'h0, 32'h0, 1'b0});
    probes.push_back('{6'd20, 32'h0080_0000, 1'b0, 32'h0, 32'h0, 1'b0});
    probes.push_back('{6'd20, 32'hFF80_0000, 1'b0, 32'h0, 32'h0, 1'b0});
    probes.push_back('{6'd0, 32'h0000_0000, 1'b1, ONE_FIX, 32'h0, 1'b0});
    probes.push_back('{6'd0, 32'h0000_0005, 1'b1, ONE_FIX, 32'h0, 1'b0});
    probes.push_back('{6'd0, 32'hFFFF_FFFB, 1'b1, M_ONE_FIX, 32'h0, 1'b0});
    probes.push_back('{6'd0, PI_W, 1'b1, ONE_FIX, 32'h0, 1'b0});
    probes.push_back('{6'd0, -PI_W, 1'b1, M_ONE_FIX, 32'h0, 1'b0});
    probes.push_back('{6'd0, 32'h8000_0000, 1'b1, ONE_FIX, M_ONE_FIX, 1'b1});
    probes.push_back('{6'd40, PI_W, 1'b0, 32'h0, 32'h0, 1'b0});
    probes.push_back('{6'd40, -PI_W, 1'b0, 32'h0, 32'h0, 1'b0});
    probes.push_back('{6'd40, 32'h0000_0000, 1'b0, 32'h0, 32'h0, 1'b0});
    probes.push_back('{6'd40, 32'd12345, 1'b0, 32'h0, 32'h0, 1'b0});
    probes.push_back('{6'd40, -32'd12345, 1'b0, 32'h0, 32'h0, 1'b0});
    probes.push_back('{6'd63, PI_W, 1'b0, 32'h0, 32'h0, 1'b0});
    probes.push_back('{6'd63, 32'h00C0_0000, 1'b0, 32'h0, 32'h0, 1'b0});
    probes.push_back('{6'd1, 32'h0100_0000, 1'b0, 32'h0, 32'h0, 1'b0});

    // reset
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part, back to back within one setting
    foreach (probes[p]) begin
      if (probes[p].iters != iter_setting) set_iterations(probes[p].iters, 1'b0);
      if (probes[p].typed) begin
        want.cosh = probes[p].cosh;
        want.sinh = probes[p].sinh;
        want.oor = probes[p].oor;
      end else begin
        want = predict_cosh_sinh(probes[p].angle, iter_setting);
      end
      send_angle(probes[p].angle, want);
    end

    // a write to an index with no register leaves the count alone
    in_valid_i <= 1'b0;
    while (cosh_sinh_q.size() != 0) @(posedge clk_i);
    apb_access(1'b1, REG_SPARE, {$urandom()}, rd);
    apb_access(1'b0, REG_ITERATION_COUNT, '0, rd);
    if (rd !== PDATA_W'(iter_setting)) report_mismatch("count after spare write", rd,
                                                        PDATA_W'(iter_setting));

    // random part, one iteration setting per phase
    phase_iters = '{6'd20, 6'd40, 6'd0, 6'd63, 6'd2, 6'd13, 6'd4, 6'd41, 6'd0, 6'd0};
    phase_iters[8] = CNT_W'($urandom_range(0, 63));
    phase_iters[9] = CNT_W'($urandom_range(0, 63));
    burst_left = $urandom_range(1, 8);
    for (phase = 0; phase < RAND_PHASES; phase++) begin
      set_iterations(phase_iters[phase], phase[0]);
      for (i = 0; i < PHASE_WORDS; i++) begin
        sel = $urandom_range(0, 19);
        if (sel <= 10) begin
          ang = WORD_W'(longint'($urandom_range(0, 2 * PI_W)) - PI_FIX);
        end else if (sel <= 13) begin
          ang = PI_W + WORD_W'($urandom_range(0, 4)) - 2;
          if ($urandom_range(0, 1)) ang = -ang;
        end else if (sel <= 16) begin
          ang = $urandom();
        end else begin
          ang = WORD_W'($urandom_range(0, 32'h0010_0000)) >> $urandom_range(0, 20);
          if ($urandom_range(0, 1)) ang = -ang;
        end
        send_angle(ang, predict_cosh_sinh(ang, iter_setting));
        // bursts with random gaps, some gaps empty
        if (burst_left == 0) begin
          gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          if (gap != 0) begin
            in_valid_i <= 1'b0;
            repeat (gap) @(posedge clk_i);
          end
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) :
                                                     $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end
    end

    // drain and finish
    in_valid_i <= 1'b0;
    while (cosh_sinh_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
